### rtl/core/sblru_pkg.sv
// shared types and constants for the size budgeted lru directory
// no dependencies
package sblru_pkg;

    localparam int KEY_FIELD_W  = 16;
    localparam int SIZE_W       = 32;
    localparam int SLOT_W       = 4;
    localparam int EKEY_W       = 16;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [SIZE_W-1:0] CAP_RESET = 32'd1048576;

    typedef enum logic [1:0] {
        KIND_HIT   = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_FAIL  = 2'd2,
        KIND_EVICT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_EVICT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic hit;
        logic fail;
        logic insert;
        logic rd_victim;
        logic evict;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic oversize;
        logic fits;
        logic full;
        logic empty;
        logic out_free;
    } sts_t;

endpackage

### rtl/core/size_budget_lru_directory.sv
// size budgeted lru cache directory: one request at a time, a new one is accepted only when idle
// a request is latched and looked up: a hit, or a refusal when oversize; otherwise it is checked
// against the budget and free slots, the oldest entry evicted until it fits, and then loaded
// the oldest entry is matched by rank combinationally, so each eviction costs a ram read and an update
// synchronous active low reset clears valid bits, ranks and byte count and loads a 1 MiB budget
// entry keys and sizes are not cleared; no clearing pass is needed
module size_budget_lru_directory #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sblru_pkg::IN_TDATA_W-1:0]    s_tdata,   // key[15:0], byte_size[47:16]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sblru_pkg::OUT_TDATA_W-1:0]   m_tdata,   // slot[3:0], evicted_key[19:4]
    output logic [1:0]                          m_tuser,   // kind[1:0]
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sblru_pkg::SIZE_W-1:0]        cfg_data
);

    sblru_pkg::cmd_t cmd;
    sblru_pkg::sts_t sts;

    logic [1:0]                     m_kind;
    logic [sblru_pkg::SLOT_W-1:0]   m_slot;
    logic [sblru_pkg::EKEY_W-1:0]   m_ekey;

    sblru_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sblru_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_key    (s_tdata[15:0]),
        .in_size   (s_tdata[47:16]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_kind    (m_kind),
        .m_slot    (m_slot),
        .m_ekey    (m_ekey),
        .m_last    (m_tlast)
    );

    assign cfg_ready = aresetn;
    assign m_tdata   = {4'b0000, m_ekey, m_slot};
    assign m_tuser   = m_kind;

endmodule

### rtl/core/sblru_ram.sv
// generic single write port ram with registered read
// no dependencies
module sblru_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/sblru_ctrl.sv
// request sequencer for the lru directory
// uses sblru_pkg
module sblru_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sblru_pkg::sts_t   sts,
    output sblru_pkg::cmd_t   cmd
);

    sblru_pkg::state_t state_reg;
    sblru_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sblru_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sblru_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sblru_pkg::ST_LOOKUP;
                end
            end
            sblru_pkg::ST_LOOKUP: begin
                if (sts.hit || sts.oversize) begin
                    if (sts.out_free) begin
                        state_next = sblru_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = sblru_pkg::ST_CHECK;
                end
            end
            sblru_pkg::ST_CHECK: begin
                if ((sts.fits && !sts.full) || sts.empty) begin
                    if (sts.out_free) begin
                        state_next = sblru_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = sblru_pkg::ST_EVICT;
                end
            end
            sblru_pkg::ST_EVICT: begin
                if (sts.out_free) begin
                    state_next = sblru_pkg::ST_CHECK;
                end
            end
            default: state_next = sblru_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            sblru_pkg::ST_IDLE: begin
                s_tready  = aresetn;
                cmd.latch = s_tvalid;
            end
            sblru_pkg::ST_LOOKUP: begin
                priority if (sts.hit) begin
                    cmd.hit = sts.out_free;
                end else if (sts.oversize) begin
                    cmd.fail = sts.out_free;
                end
            end
            sblru_pkg::ST_CHECK: begin
                priority if (sts.fits && !sts.full) begin
                    cmd.insert = sts.out_free;
                end else if (sts.empty) begin
                    cmd.fail = sts.out_free;
                end else begin
                    cmd.rd_victim = 1'b1;
                end
            end
            sblru_pkg::ST_EVICT: begin
                cmd.evict = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

### rtl/core/sblru_dp.sv
// directory datapath: key match cells, recency ranks, byte count, output register
// uses sblru_pkg and sblru_ram
module sblru_dp #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sblru_pkg::cmd_t                     cmd,
    output sblru_pkg::sts_t                     sts,
    input  logic [sblru_pkg::KEY_FIELD_W-1:0]   in_key,
    input  logic [sblru_pkg::SIZE_W-1:0]        in_size,
    input  logic                                cfg_valid,
    input  logic [sblru_pkg::SIZE_W-1:0]        cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [1:0]                          m_kind,
    output logic [sblru_pkg::SLOT_W-1:0]        m_slot,
    output logic [sblru_pkg::EKEY_W-1:0]        m_ekey,
    output logic                                m_last
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SIZE_W = sblru_pkg::SIZE_W;
    localparam int RAM_W  = KEY_BITS + SIZE_W;

    logic [KEY_BITS-1:0] key_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [SIZE_W-1:0]   cap_reg;
    logic [SIZE_W-1:0]   bytes_reg;
    logic [SIZE_W-1:0]   bytes_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;
    logic [IDX_W-1:0]    rank_reg [ENTRIES];
    logic [IDX_W-1:0]    rank_next [ENTRIES];
    logic [KEY_BITS-1:0] ent_key_reg [ENTRIES];
    logic [IDX_W-1:0]    victim_reg;

    logic [ENTRIES-1:0]  hit_vec;
    logic [ENTRIES-1:0]  old_vec;
    logic [IDX_W-1:0]    hit_idx;
    logic [IDX_W-1:0]    old_idx;
    logic [IDX_W-1:0]    free_idx;
    logic [IDX_W-1:0]    hit_rank;
    logic [CNT_W-1:0]    top_rank;

    logic [RAM_W-1:0]    ram_rd_data;
    logic [SIZE_W-1:0]   ev_size;
    logic [KEY_BITS-1:0] ev_key;

    logic                          m_tvalid_reg;
    logic [1:0]                    m_kind_reg;
    logic [sblru_pkg::SLOT_W-1:0]  m_slot_reg;
    logic [sblru_pkg::EKEY_W-1:0]  m_ekey_reg;
    logic                          m_last_reg;
    logic                          emit;

    // victim record: key and size of each slot
    sblru_ram #(
        .WIDTH(RAM_W),
        .DEPTH(ENTRIES)
    ) u_ent_ram (
        .aclk    (aclk),
        .wr_en   (cmd.insert),
        .wr_addr (free_idx),
        .wr_data ({key_reg, size_reg}),
        .rd_en   (cmd.rd_victim),
        .rd_addr (old_idx),
        .rd_data (ram_rd_data)
    );

    assign ev_key  = ram_rd_data[RAM_W-1:SIZE_W];
    assign ev_size = ram_rd_data[SIZE_W-1:0];

    // oldest valid entry carries rank count-1
    assign top_rank = count_reg - 1'b1;

    always_comb begin
        hit_idx  = '0;
        old_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = valid_reg[i] && (ent_key_reg[i] == key_reg);
            old_vec[i] = valid_reg[i] && (CNT_W'(rank_reg[i]) == top_rank);
            if (hit_vec[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (old_vec[i]) begin
                old_idx = old_idx | IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit_rank = rank_reg[hit_idx];
    assign emit     = cmd.hit || cmd.fail || cmd.insert || cmd.evict;

    assign sts.hit      = |hit_vec;
    assign sts.oversize = size_reg > cap_reg;
    assign sts.fits     = ({1'b0, bytes_reg} + {1'b0, size_reg}) <= {1'b0, cap_reg};
    assign sts.full     = count_reg == CNT_W'(ENTRIES);
    assign sts.empty    = count_reg == '0;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        rank_next  = rank_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        bytes_next = bytes_reg;
        if (cmd.hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            rank_next[hit_idx] = '0;
        end
        if (cmd.insert) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (valid_reg[i]) begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            rank_next[free_idx]  = '0;
            valid_next[free_idx] = 1'b1;
            count_next           = count_reg + 1'b1;
            bytes_next           = bytes_reg + size_reg;
        end
        if (cmd.evict) begin
            valid_next[victim_reg] = 1'b0;
            count_next             = count_reg - 1'b1;
            bytes_next             = (ev_size > bytes_reg) ? '0 : bytes_reg - ev_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            bytes_reg <= '0;
            cap_reg   <= sblru_pkg::CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            bytes_reg <= bytes_next;
            rank_reg  <= rank_next;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            key_reg  <= KEY_BITS'(in_key);
            size_reg <= in_size;
        end
        if (cmd.insert) begin
            ent_key_reg[free_idx] <= key_reg;
        end
        if (cmd.rd_victim) begin
            victim_reg <= old_idx;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_last_reg <= !cmd.evict;
            m_ekey_reg <= '0;
            m_slot_reg <= '0;
            priority if (cmd.hit) begin
                m_kind_reg <= sblru_pkg::KIND_HIT;
                m_slot_reg <= sblru_pkg::SLOT_W'(hit_idx);
            end else if (cmd.insert) begin
                m_kind_reg <= sblru_pkg::KIND_LOAD;
                m_slot_reg <= sblru_pkg::SLOT_W'(free_idx);
            end else if (cmd.evict) begin
                m_kind_reg <= sblru_pkg::KIND_EVICT;
                m_slot_reg <= sblru_pkg::SLOT_W'(victim_reg);
                m_ekey_reg <= sblru_pkg::EKEY_W'(ev_key);
            end else begin
                m_kind_reg <= sblru_pkg::KIND_FAIL;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_kind   = m_kind_reg;
    assign m_slot   = m_slot_reg;
    assign m_ekey   = m_ekey_reg;
    assign m_last   = m_last_reg;

    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("valid count out of step with valid bits");

    a_evict_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict |-> valid_reg[victim_reg])
        else $error("eviction of an invalid slot");

    a_insert_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> (!valid_reg[free_idx] && (count_reg != CNT_W'(ENTRIES))))
        else $error("insert into an occupied slot");

    a_emit_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid_reg)
        else $error("result lost before output register");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrites one not yet taken");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// testbench for size_budget_lru_directory: random and directed cache requests under
// several byte budgets, checked against a local lru directory predictor
// depends on sblru_pkg and the size_budget_lru_directory rtl only
module tb;

    localparam int DEPTH        = 16;
    localparam int POOL         = 22;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int KEY_W        = sblru_pkg::KEY_FIELD_W;
    localparam int SIZE_W       = sblru_pkg::SIZE_W;
    localparam int SLOT_W       = sblru_pkg::SLOT_W;
    localparam int EKEY_W       = sblru_pkg::EKEY_W;
    localparam int IN_W         = sblru_pkg::IN_TDATA_W;
    localparam int OUT_W        = sblru_pkg::OUT_TDATA_W;

    typedef struct packed {
        logic [SIZE_W-1:0] byte_size;
        logic [KEY_W-1:0]  key;
    } request_t;

    typedef struct packed {
        sblru_pkg::kind_t   kind;
        logic [SLOT_W-1:0]  slot;
        logic [EKEY_W-1:0]  evicted_key;
        logic               last;
    } dir_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data = '0;

    request_t    request_queue[$];
    dir_result_t directory_outcomes[$];
    dir_result_t head_outcome;

    // predictor copy of the directory
    logic [KEY_W-1:0]  ent_key [DEPTH];
    logic [SIZE_W-1:0] ent_size [DEPTH];
    logic              ent_valid [DEPTH];
    logic [SLOT_W-1:0] ent_rank [DEPTH];
    logic [SIZE_W-1:0] bytes_used;
    logic [SIZE_W-1:0] capacity;

    logic [KEY_W-1:0]  key_pool [POOL];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_cap_writes = 0;
    int n_hits = 0;
    int n_loads = 0;
    int n_refusals = 0;
    int n_evictions = 0;

    size_budget_lru_directory u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic void note_outcome(sblru_pkg::kind_t kind, int slot,
                                         logic [EKEY_W-1:0] ekey, logic last);
        dir_result_t r;
        r.kind = kind;
        r.slot = SLOT_W'(slot);
        r.evicted_key = ekey;
        r.last = last;
        directory_outcomes.push_back(r);
        unique case (kind)
            sblru_pkg::KIND_HIT:   n_hits++;
            sblru_pkg::KIND_LOAD:  n_loads++;
            sblru_pkg::KIND_FAIL:  n_refusals++;
            sblru_pkg::KIND_EVICT: n_evictions++;
        endcase
    endfunction

    function automatic int lowest_free_slot();
        int i;
        for (i = 0; i < DEPTH; i++)
            if (!ent_valid[i])
                return i;
        return -1;
    endfunction

    function automatic void directory_lookup(logic [KEY_W-1:0] key,
                                             logic [SIZE_W-1:0] size);
        int i;
        int hit_slot;
        int victim;
        int free_idx;
        logic [SLOT_W-1:0] old_rank;
        hit_slot = -1;
        for (i = 0; i < DEPTH; i++)
            if (ent_valid[i] && ent_key[i] == key)
                hit_slot = i;
        if (hit_slot >= 0) begin
            old_rank = ent_rank[hit_slot];
            for (i = 0; i < DEPTH; i++)
                if (ent_valid[i] && i != hit_slot && ent_rank[i] < old_rank)
                    ent_rank[i]++;
            ent_rank[hit_slot] = '0;
            note_outcome(sblru_pkg::KIND_HIT, hit_slot, '0, 1'b1);
            return;
        end
        if (size > capacity) begin
            note_outcome(sblru_pkg::KIND_FAIL, 0, '0, 1'b1);
            return;
        end
        // evict least recent entries until bytes fit and a slot is free
        free_idx = lowest_free_slot();
        while ({1'b0, bytes_used} + {1'b0, size} > {1'b0, capacity} || free_idx < 0) begin
            victim = -1;
            for (i = 0; i < DEPTH; i++)
                if (ent_valid[i] && (victim < 0 || ent_rank[i] > ent_rank[victim]))
                    victim = i;
            if (victim < 0) begin
                note_outcome(sblru_pkg::KIND_FAIL, 0, '0, 1'b1);
                return;
            end
            ent_valid[victim] = 1'b0;
            bytes_used = (ent_size[victim] > bytes_used) ? '0 : bytes_used - ent_size[victim];
            note_outcome(sblru_pkg::KIND_EVICT, victim, ent_key[victim], 1'b0);
            free_idx = lowest_free_slot();
        end
        for (i = 0; i < DEPTH; i++)
            if (ent_valid[i])
                ent_rank[i]++;
        ent_valid[free_idx] = 1'b1;
        ent_key[free_idx] = key;
        ent_size[free_idx] = size;
        ent_rank[free_idx] = '0;
        bytes_used = bytes_used + size;
        note_outcome(sblru_pkg::KIND_LOAD, free_idx, '0, 1'b1);
    endfunction

    function automatic void push_request(logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size);
        request_t r;
        r.key = key;
        r.byte_size = size;
        request_queue.push_back(r);
    endfunction

    task automatic queue_random_requests(int count, logic [SIZE_W-1:0] size_cap);
        int n;
        logic [KEY_W-1:0] key;
        logic [SIZE_W-1:0] size;
        @(negedge aclk);
        for (n = 0; n < count; n++) begin
            if ($urandom_range(99) < 88)
                key = key_pool[$urandom_range(POOL - 1)];
            else
                key = KEY_W'($urandom);
            if ($urandom_range(99) < 8)
                size = $urandom;
            else
                size = $urandom_range(size_cap);
            push_request(key, size);
        end
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || s_tvalid || directory_outcomes.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_capacity(logic [SIZE_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        capacity = value;
        n_cap_writes++;
    endtask

    // request driver with prediction on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                directory_lookup(s_tdata[KEY_W-1:0], s_tdata[IN_W-1:KEY_W]);
                n_requests++;
            end
            if (!s_tvalid || s_tready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata <= request_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (directory_outcomes.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none", $time);
                    $display("%0t:   got kind %0d slot %0d key %h last %b",
                             $time, m_tuser, m_tdata[3:0], m_tdata[19:4], m_tlast);
                end else begin
                    head_outcome = directory_outcomes.pop_front();
                    if (m_tuser !== head_outcome.kind ||
                        m_tdata[3:0] !== head_outcome.slot ||
                        m_tdata[19:4] !== head_outcome.evicted_key ||
                        m_tlast !== head_outcome.last) begin
                        errors++;
                        $display("%0t: mismatch, expected kind %0d slot %0d key %h last %b",
                                 $time, head_outcome.kind, head_outcome.slot,
                                 head_outcome.evicted_key, head_outcome.last);
                        $display("%0t:           actual kind %0d slot %0d key %h last %b",
                                 $time, m_tuser, m_tdata[3:0], m_tdata[19:4], m_tlast);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        int seen;
        int now_count;
        quiet = 0;
        seen = 0;
        while (quiet < STALL_LIMIT) begin
            @(negedge aclk);
            now_count = n_requests + n_results + n_cap_writes;
            if (now_count != seen) begin
                quiet = 0;
                seen = now_count;
            end else begin
                quiet++;
            end
        end
        $display("size_budget_lru_directory test failed");
        $finish;
    end

    initial begin
        int k;
        for (k = 0; k < DEPTH; k++) begin
            ent_valid[k] = 1'b0;
            ent_rank[k] = '0;
            ent_key[k] = '0;
            ent_size[k] = '0;
        end
        for (k = 0; k < POOL; k++)
            key_pool[k] = KEY_W'($urandom);
        bytes_used = '0;
        capacity = sblru_pkg::CAP_RESET;
        send_idle_pct = 14;
        recv_idle_pct = 54;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, zero size, exact fit, oversize, hit, byte and slot evictions
        @(negedge aclk);
        push_request(16'h0000, 32'd0);
        push_request(16'hFFFF, sblru_pkg::CAP_RESET);
        push_request(16'h0000, 32'd5);
        push_request(16'h1234, 32'hFFFF_FFFF);
        push_request(16'h0001, 32'd1);
        for (k = 2; k <= 16; k++)
            push_request(KEY_W'(k), 32'd0);
        push_request(16'h0001, 32'hFFFF_FFFF);
        wait_idle();

        write_capacity(32'd0);
        queue_random_requests(24, 32'd0);
        wait_idle();

        write_capacity(32'd65536);
        queue_random_requests(130, 32'd20000);
        wait_idle();

        // budget below bytes in use
        write_capacity(32'd3000);
        @(negedge aclk);
        send_idle_pct = 54;
        recv_idle_pct = 14;
        queue_random_requests(100, 32'd1000);
        wait_idle();

        write_capacity(32'hFFFF_FFFF);
        queue_random_requests(100, 32'hFFFF_FFFF);
        wait_idle();

        write_capacity(sblru_pkg::CAP_RESET);
        @(negedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_requests(100, 32'd300000);
        wait_idle();

        $display("ran %0d requests over %0d budget settings, %0d results checked",
                 n_requests, n_cap_writes + 1, n_results);
        $display("outcomes: %0d hits, %0d loads, %0d refusals, %0d evictions",
                 n_hits, n_loads, n_refusals, n_evictions);
        if (errors == 0) begin
            $display("size_budget_lru_directory test passed");
        end else begin
            $display("size_budget_lru_directory test failed");
        end
        $finish;
    end

endmodule
